FILE: sv/rmd160_pkg.sv
// ----------------------------------------------------------------------------
// rmd160_pkg
// Types, round tables and helper functions for the RIPEMD-160 single-block
// hash pipeline (fixed 32-byte message).
// ----------------------------------------------------------------------------
package rmd160_pkg;

  localparam int unsigned NumRounds = 80;

  // Standard initial chaining values
  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hefcdab89;
  localparam logic [31:0] Iv2 = 32'h98badcfe;
  localparam logic [31:0] Iv3 = 32'h10325476;
  localparam logic [31:0] Iv4 = 32'hc3d2e1f0;

  // Padding words of the single block: 0x80 byte and the bit length 256
  localparam logic [31:0] PadWord   = 32'h00000080;
  localparam logic [31:0] LengthBit = 32'h00000100;

  localparam logic [3:0] WordLeft [NumRounds] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
    4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
    4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
    4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
    4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
    4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2,
    4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10,
    4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6, 4'd15, 4'd13
  };

  localparam logic [3:0] WordRight [NumRounds] = '{
    4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
    4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
    4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
    4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
    4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
    4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
    4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
    4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14,
    4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7,
    4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3, 4'd9, 4'd11
  };

  localparam logic [3:0] RotLeft [NumRounds] = '{
    4'd11, 4'd14, 4'd15, 4'd12, 4'd5, 4'd8, 4'd7, 4'd9,
    4'd11, 4'd13, 4'd14, 4'd15, 4'd6, 4'd7, 4'd9, 4'd8,
    4'd7, 4'd6, 4'd8, 4'd13, 4'd11, 4'd9, 4'd7, 4'd15,
    4'd7, 4'd12, 4'd15, 4'd9, 4'd11, 4'd7, 4'd13, 4'd12,
    4'd11, 4'd13, 4'd6, 4'd7, 4'd14, 4'd9, 4'd13, 4'd15,
    4'd14, 4'd8, 4'd13, 4'd6, 4'd5, 4'd12, 4'd7, 4'd5,
    4'd11, 4'd12, 4'd14, 4'd15, 4'd14, 4'd15, 4'd9, 4'd8,
    4'd9, 4'd14, 4'd5, 4'd6, 4'd8, 4'd6, 4'd5, 4'd12,
    4'd9, 4'd15, 4'd5, 4'd11, 4'd6, 4'd8, 4'd13, 4'd12,
    4'd5, 4'd12, 4'd13, 4'd14, 4'd11, 4'd8, 4'd5, 4'd6
  };

  localparam logic [3:0] RotRight [NumRounds] = '{
    4'd8, 4'd9, 4'd9, 4'd11, 4'd13, 4'd15, 4'd15, 4'd5,
    4'd7, 4'd7, 4'd8, 4'd11, 4'd14, 4'd14, 4'd12, 4'd6,
    4'd9, 4'd13, 4'd15, 4'd7, 4'd12, 4'd8, 4'd9, 4'd11,
    4'd7, 4'd7, 4'd12, 4'd7, 4'd6, 4'd15, 4'd13, 4'd11,
    4'd9, 4'd7, 4'd15, 4'd11, 4'd8, 4'd6, 4'd6, 4'd14,
    4'd12, 4'd13, 4'd5, 4'd14, 4'd13, 4'd13, 4'd7, 4'd5,
    4'd15, 4'd5, 4'd8, 4'd11, 4'd14, 4'd14, 4'd6, 4'd14,
    4'd6, 4'd9, 4'd12, 4'd9, 4'd12, 4'd5, 4'd15, 4'd8,
    4'd8, 4'd5, 4'd12, 4'd9, 4'd12, 4'd5, 4'd14, 4'd6,
    4'd8, 4'd13, 4'd6, 4'd5, 4'd15, 4'd13, 4'd11, 4'd11
  };

  localparam logic [31:0] AddLeft [5] = '{
    32'h00000000, 32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'ha953fd4e
  };

  localparam logic [31:0] AddRight [5] = '{
    32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3, 32'h7a6d76e9, 32'h00000000
  };

  // Request payload: the eight little-endian message words
  typedef struct packed {
    logic [31:0] msg_word0;
    logic [31:0] msg_word1;
    logic [31:0] msg_word2;
    logic [31:0] msg_word3;
    logic [31:0] msg_word4;
    logic [31:0] msg_word5;
    logic [31:0] msg_word6;
    logic [31:0] msg_word7;
  } rmd_in_t;

  // Result payload: the five digest words
  typedef struct packed {
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;
    logic [31:0] digest_word4;
  } rmd_out_t;

  // Working variables of one line
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } rmd_line_t;

  // Contents of one pipeline stage
  typedef struct packed {
    logic [7:0][31:0] msg;
    rmd_line_t        left;
    rmd_line_t        right;
  } rmd_stage_t;

  function automatic logic [31:0] rotl32(logic [31:0] x, logic [3:0] n);
    logic [63:0] dbl;
    dbl = {x, x} << n;
    return dbl[63:32];
  endfunction

  function automatic logic [31:0] bool_fn(logic [2:0] sel, logic [31:0] x,
                                          logic [31:0] y, logic [31:0] z);
    logic [31:0] r;
    case (sel)
      3'd0:    r = x ^ y ^ z;
      3'd1:    r = (x & y) | (~x & z);
      3'd2:    r = (x | ~y) ^ z;
      3'd3:    r = (x & z) | (y & ~z);
      default: r = x ^ (y | ~z);
    endcase
    return r;
  endfunction

  // Block word: message words first, then the fixed padding and length
  function automatic logic [31:0] block_word(logic [7:0][31:0] msg, logic [3:0] idx);
    logic [31:0] r;
    if (!idx[3]) begin
      r = msg[idx[2:0]];
    end else if (idx == 4'd8) begin
      r = PadWord;
    end else if (idx == 4'd14) begin
      r = LengthBit;
    end else begin
      r = 32'd0;
    end
    return r;
  endfunction

  function automatic rmd_line_t line_step(rmd_line_t s, logic [2:0] sel,
                                          logic [31:0] w, logic [31:0] k,
                                          logic [3:0] rot);
    rmd_line_t   n;
    logic [31:0] t;
    t   = s.a + bool_fn(sel, s.b, s.c, s.d) + w + k;
    t   = rotl32(t, rot) + s.e;
    n.a = s.e;
    n.e = s.d;
    n.d = rotl32(s.c, 4'd10);
    n.c = s.b;
    n.b = t;
    return n;
  endfunction

  // One round of both lines; j is fixed per stage so the tables fold away
  function automatic rmd_stage_t rmd_round(rmd_stage_t s, logic [6:0] j);
    rmd_stage_t n;
    logic [2:0] grp;
    grp     = j[6:4];
    n.msg   = s.msg;
    n.left  = line_step(s.left, grp, block_word(s.msg, WordLeft[j]),
                        AddLeft[grp], RotLeft[j]);
    n.right = line_step(s.right, 3'd4 - grp, block_word(s.msg, WordRight[j]),
                        AddRight[grp], RotRight[j]);
    return n;
  endfunction

endpackage

FILE: sv/ripemd160_32byte_message_top.sv
// ----------------------------------------------------------------------------
// ripemd160_32byte_message_top
// RIPEMD-160 digest of a 32-byte message, one fully unrolled round per stage.
// ----------------------------------------------------------------------------
// Usage:
//   msg channel (msg_valid/msg_ready/msg) takes one request: the 32-byte
//   message as eight little-endian words. Padding and length are fixed
//   inside. digest channel (digest_valid/digest_ready/digest) returns the
//   five digest words, one result per request, in request order.
//   Throughput: one request per cycle while the output is not stalled.
//   The 80 rounds sit in 80 register stages, one round of both lines in
//   each, behind an input stage and in front of an output register.
//   Reset (rst, synchronous) clears all stage valid bits and the output
//   valid; requests in flight are dropped.
//   Stall: while digest_valid is high and digest_ready is low, the whole
//   pipeline holds and msg_ready is low; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ripemd160_32byte_message_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 msg_valid,
  output logic                 msg_ready,
  input  rmd160_pkg::rmd_in_t  msg,
  output logic                 digest_valid,
  input  logic                 digest_ready,
  output rmd160_pkg::rmd_out_t digest
);
  import rmd160_pkg::*;

  logic                 adv;
  logic [NumRounds:0]   stage_valid;
  rmd_stage_t           stage      [NumRounds+1];
  rmd_stage_t           stage_next [NumRounds+1];
  rmd_out_t             digest_next;

  // Advance whenever the output register is free or being emptied
  assign adv       = !digest_valid || digest_ready;
  assign msg_ready = adv;

  // Load the message (word 7 highest) and the initial values of both lines
  assign stage_next[0] = {msg.msg_word7, msg.msg_word6, msg.msg_word5, msg.msg_word4,
                          msg.msg_word3, msg.msg_word2, msg.msg_word1, msg.msg_word0,
                          Iv0, Iv1, Iv2, Iv3, Iv4,
                          Iv0, Iv1, Iv2, Iv3, Iv4};

  // One round of both lines between neighbouring stages
  for (genvar j = 0; j < NumRounds; j++) begin : g_round
    assign stage_next[j+1] = rmd_round(stage[j], 7'(j));
  end

  // Advance stage data and valid bits together
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (adv) begin
      stage_valid <= {stage_valid[NumRounds-1:0], msg_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= NumRounds; k++) begin
        stage[k] <= stage_next[k];
      end
    end
  end

  // Cross-add the two lines into the initial values
  always_comb begin
    digest_next.digest_word0 = Iv1 + stage[NumRounds].left.c + stage[NumRounds].right.d;
    digest_next.digest_word1 = Iv2 + stage[NumRounds].left.d + stage[NumRounds].right.e;
    digest_next.digest_word2 = Iv3 + stage[NumRounds].left.e + stage[NumRounds].right.a;
    digest_next.digest_word3 = Iv4 + stage[NumRounds].left.a + stage[NumRounds].right.b;
    digest_next.digest_word4 = Iv0 + stage[NumRounds].left.b + stage[NumRounds].right.c;
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      digest_valid <= 1'b0;
    end else if (adv) begin
      digest_valid <= stage_valid[NumRounds];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      digest <= digest_next;
    end
  end

`ifndef ASSERT_OFF
  a_hold_on_stall : assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(stage_valid))
    else $error("stage valid bits moved during a stall");

  a_shift_on_adv : assert property (@(posedge clk) disable iff (rst)
    adv |=> stage_valid[NumRounds:1] == $past(stage_valid[NumRounds-1:0]))
    else $error("stage valid bits did not shift on advance");

  a_last_to_out : assert property (@(posedge clk) disable iff (rst)
    adv && stage_valid[NumRounds] |=> digest_valid)
    else $error("last round stage did not reach the output register");
`endif

endmodule
